### rtl/xml_entity_decoder_top_assert.svh
// Assertion macros for the entity decoder top level.
`ifndef XML_ENTITY_DECODER_TOP_ASSERT_SVH
`define XML_ENTITY_DECODER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define XED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define XED_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/xed_pkg.sv
`timescale 1ns / 1ps
package xed_pkg;

  localparam int BYTE_W    = 8;
  localparam int HOLD_MAX  = 5;
  localparam int OUT_MAX   = 6;
  localparam int ENT_COUNT = 5;
  localparam int CNT_W     = 3;
  localparam int QDEPTH    = 2;

  localparam logic [BYTE_W-1:0] AMP = 8'h26;

  localparam logic [BYTE_W-1:0] ENT_TEXT [ENT_COUNT][OUT_MAX] = '{
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
    '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}
  };

  localparam logic [CNT_W-1:0] ENT_LEN [ENT_COUNT] = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd6};

  localparam logic [BYTE_W-1:0] ENT_CHAR [ENT_COUNT] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    logic [OUT_MAX-1:0][BYTE_W-1:0] bytes;
    logic                      last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/xml_entity_decoder_top.sv
`timescale 1ns / 1ps
// channel   valid      stall      payload
// in        in_valid   in_stall   in_byte, in_last
// out       out_valid  out_stall  out_byte, out_last
//
// One input byte per cycle while in_stall is low; out_stall holds bytes on the out side.
// A broken match flushes up to six bytes, which the back end sends one at a time.
// Requests pass through the queue; out_valid rises when the back end loads one.
// in_stall rises only when the request queue between front and back is full.
// Synchronous active-low reset clears match state, queue and output valid.
`include "xml_entity_decoder_top_assert.svh"
module xml_entity_decoder_top
  import xed_pkg::*;
#(
  parameter int QUEUE_DEPTH = QDEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  byte_t in_byte,
  input  logic  in_last,
  output logic  out_valid,
  input  logic  out_stall,
  output byte_t out_byte,
  output logic  out_last
);

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head_cmd;
  q_status_t q_status;

  xed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  xed_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_status (q_status)
  );

  xed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  `XED_ASSERT_IMP(a_last_pushes, in_valid && !in_stall && in_last, push, "last byte gave no request")
  `XED_ASSERT_IMP(a_push_count, push, (push_cmd.cnt != 3'd0) && (push_cmd.cnt <= 3'd6), "bad request count")
  `XED_ASSERT_IMP(a_pop_nonempty, pop, !q_status.empty, "pop from empty queue")
  `XED_ASSERT_NXT(a_pop_shows, pop, out_valid, "popped request not shown")

endmodule

### rtl/xed_front.sv
`timescale 1ns / 1ps
module xed_front
  import xed_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  byte_t     in_byte,
  input  logic      in_last,
  input  q_status_t q_status,
  output logic      push,
  output cmd_t      push_cmd
);

  byte_t            held_r   [HOLD_MAX];
  byte_t            held_nxt [HOLD_MAX];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                 accept;
  logic [CNT_W-1:0]     len;
  logic [ENT_COUNT-1:0] full_hit;
  logic [ENT_COUNT-1:0] pref_hit;
  logic                 match;
  byte_t                full_char;
  logic                 is_full, is_pref;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign len      = cnt_r + 3'd1;

  always_comb begin
    for (int e = 0; e < ENT_COUNT; e++) begin
      match = 1'b1;
      for (int i = 0; i < HOLD_MAX; i++) begin
        if (CNT_W'(i) < cnt_r && held_r[i] != ENT_TEXT[e][i]) begin
          match = 1'b0;
        end
      end
      for (int i = 0; i < OUT_MAX; i++) begin
        if (CNT_W'(i) == cnt_r && in_byte != ENT_TEXT[e][i]) begin
          match = 1'b0;
        end
      end
      full_hit[e] = match && (len == ENT_LEN[e]);
      pref_hit[e] = match && (len < ENT_LEN[e]);
    end
  end

  always_comb begin
    full_char = '0;
    for (int e = 0; e < ENT_COUNT; e++) begin
      if (full_hit[e]) begin
        full_char = full_char | ENT_CHAR[e];
      end
    end
  end

  assign is_full = |full_hit;
  assign is_pref = (|pref_hit) && (cnt_r < CNT_W'(HOLD_MAX));

  always_comb begin
    cnt_nxt       = cnt_r;
    held_nxt      = held_r;
    push_cmd.last = in_last;
    push_cmd.cnt  = '0;
    for (int i = 0; i < OUT_MAX; i++) begin
      push_cmd.bytes[i] = in_byte;
    end
    for (int i = 0; i < HOLD_MAX; i++) begin
      if (CNT_W'(i) < cnt_r) begin
        push_cmd.bytes[i] = held_r[i];
      end
    end
    if (is_full) begin
      push_cmd.bytes[0] = full_char;
      push_cmd.cnt      = 3'd1;
      cnt_nxt           = '0;
    end else if (is_pref && !in_last) begin
      for (int i = 0; i < HOLD_MAX; i++) begin
        if (CNT_W'(i) == cnt_r) begin
          held_nxt[i] = in_byte;
        end
      end
      cnt_nxt = len;
    end else if (is_pref) begin
      push_cmd.cnt = len;
      cnt_nxt      = '0;
    end else if (in_byte == AMP && !in_last) begin
      held_nxt[0]  = in_byte;
      push_cmd.cnt = cnt_r;
      cnt_nxt      = 3'd1;
    end else begin
      push_cmd.cnt = len;
      cnt_nxt      = '0;
    end
  end

  assign push = accept && (push_cmd.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

### rtl/xed_cmd_queue.sv
`timescale 1ns / 1ps
module xed_cmd_queue
  import xed_pkg::*;
#(
  parameter int DEPTH = QDEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head_cmd,
  output q_status_t q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  cmd_t              mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;

  assign head_cmd       = mem_r[rd_ptr_r];
  assign q_status.full  = (count_r == CNT_QW'(DEPTH));
  assign q_status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/xed_back.sv
`timescale 1ns / 1ps
module xed_back
  import xed_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head_cmd,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output byte_t     out_byte,
  output logic      out_last
);

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  byte_t            out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic             load;
  logic             at_end;
  byte_t            sel_byte;

  assign load   = !q_status.empty && (!out_valid_r || !out_stall);
  assign at_end = (idx_r == CNT_W'(head_cmd.cnt - 3'd1));
  assign pop    = load && at_end;

  always_comb begin
    sel_byte = head_cmd.bytes[0];
    for (int i = 0; i < OUT_MAX; i++) begin
      if (idx_r == CNT_W'(i)) begin
        sel_byte = head_cmd.bytes[i];
      end
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = sel_byte;
      out_last_nxt  = head_cmd.last && at_end;
      idx_nxt       = at_end ? '0 : idx_r + 3'd1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

### bench/xed_checker.sv
`timescale 1ns / 1ps
module xed_checker
  import xed_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_stall,
  input  byte_t in_byte,
  input  logic  in_last,
  input  logic  out_valid,
  input  logic  out_stall,
  input  byte_t out_byte,
  input  logic  out_last,
  output int    fail_count,
  output int    pending
);

  localparam int MAX_HELD     = 5;
  localparam int ENTITY_TOTAL = 5;

  localparam byte_t ENTITY_SPELLING [ENTITY_TOTAL][MAX_HELD+1] = '{
    '{"&", "l", "t", ";", 8'h00, 8'h00},
    '{"&", "g", "t", ";", 8'h00, 8'h00},
    '{"&", "a", "m", "p", ";", 8'h00},
    '{"&", "q", "u", "o", "t", ";"},
    '{"&", "a", "p", "o", "s", ";"}
  };
  localparam int    ENTITY_LENGTH [ENTITY_TOTAL] = '{4, 4, 5, 6, 6};
  localparam byte_t ENTITY_GLYPH  [ENTITY_TOTAL] = '{"<", ">", "&", "\"", "'"};

  byte_t      held_text [MAX_HELD];
  int         held_len;
  logic [8:0] expected_chars [$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic push_char(input byte_t c);
    expected_chars.insert(expected_chars.size(), {1'b0, c});
  endtask

  task automatic flush_held_text();
    for (int i = 0; i < held_len; i++) push_char(held_text[i]);
    held_len = 0;
  endtask

  task automatic begin_candidate(input byte_t c);
    if (c == "&") begin
      held_text[0] = c;
      held_len = 1;
    end else begin
      push_char(c);
    end
  endtask

  task automatic decode_byte(input byte_t c, input logic is_last);
    byte_t      cand [MAX_HELD+1];
    int         cand_len;
    int         match;
    bit         partial;
    bit         same;
    int         size_before;
    logic [8:0] tail;
    size_before = expected_chars.size();
    if (held_len == 0) begin
      begin_candidate(c);
    end else begin
      for (int i = 0; i < held_len; i++) cand[i] = held_text[i];
      cand[held_len] = c;
      cand_len = held_len + 1;
      match = -1;
      partial = 1'b0;
      for (int e = 0; e < ENTITY_TOTAL; e++) begin
        if (cand_len <= ENTITY_LENGTH[e]) begin
          same = 1'b1;
          for (int k = 0; k < cand_len; k++)
            if (ENTITY_SPELLING[e][k] != cand[k]) same = 1'b0;
          if (same) begin
            if (cand_len == ENTITY_LENGTH[e]) match = e;
            else partial = 1'b1;
          end
        end
      end
      if (match >= 0) begin
        held_len = 0;
        push_char(ENTITY_GLYPH[match]);
      end else if (partial && held_len < MAX_HELD) begin
        held_text[held_len] = c;
        held_len++;
      end else begin
        flush_held_text();
        begin_candidate(c);
      end
    end
    if (is_last) begin
      flush_held_text();
      if (expected_chars.size() > size_before) begin
        tail = expected_chars[expected_chars.size() - 1];
        expected_chars[expected_chars.size() - 1] = tail | 9'h100;
      end
    end
  endtask

  always @(posedge clk) begin
    logic [8:0] want;
    if (!rst_n) begin
      expected_chars.delete();
      held_len = 0;
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, out_last));
        end else begin
          want = expected_chars.pop_front();
          if (out_byte !== want[7:0])
            report_mismatch($sformatf("byte %02h, want %02h", out_byte, want[7:0]));
          if (out_last !== want[8])
            report_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                      out_last, want[8], want[7:0]));
        end
      end
      if (in_valid && !in_stall) decode_byte(in_byte, in_last);
    end
    pending <= expected_chars.size();
  end

endmodule

### bench/tb_xml_entity_decoder_top.sv
`timescale 1ns / 1ps
module tb_xml_entity_decoder_top;
  import xed_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int STREAM_BYTES = 360;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  byte_t in_byte = '0;
  logic  in_last = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  byte_t out_byte;
  logic  out_last;

  int fail_count;
  int pending;
  int sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit long_hold_req = 1'b0;

  string entity_name [5] = '{"&lt;", "&gt;", "&amp;", "&quot;", "&apos;"};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  xml_entity_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  xed_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int mode;
    int span;
    int phase;
    int held;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(posedge clk);
        phase++;
        if (long_hold_req) begin
          out_stall <= 1'b1;
          held = 1;
          while (held < LONG_HOLD) begin
            @(posedge clk);
            held++;
          end
          long_hold_req = 1'b0;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= ((phase % 5) < 2);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  task automatic offer(input byte_t b, input logic l);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic send_string(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) offer(s[i], last_at_end && (i == s.len() - 1));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic send_random_token();
    int    kind;
    int    cut;
    string word;
    logic  l;
    kind = $urandom_range(0, 9);
    word = entity_name[$urandom_range(0, 4)];
    l = ($urandom_range(0, 15) == 0);
    if (kind < 5) begin
      send_string(word, l);
    end else if (kind < 7) begin
      cut = $urandom_range(1, word.len() - 1);
      send_string(word.substr(0, cut - 1), 1'b0);
      if ($urandom_range(0, 1) == 0) offer("&", l);
      else offer(byte_t'($urandom_range(0, 255)), l);
    end else if (kind < 9) begin
      offer(byte_t'($urandom_range(0, 255)), l);
    end else begin
      offer("&", l);
    end
  endtask

  initial begin
    bit hold_done;
    bit pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    offer(8'h00, 1'b0);
    offer(8'hFF, 1'b0);
    send_string("&quotX", 1'b0);
    send_string("&amp;lt;", 1'b0);
    send_string("&&gt;", 1'b0);
    send_string("&ap", 1'b1);
    wait_for_drain();

    while (sent < STREAM_BYTES) begin
      if (!hold_done && sent >= 150) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && sent >= 260) begin
        wait_for_drain();
        pause_done = 1'b1;
      end
      send_random_token();
    end

    wait_for_drain();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/xed_pkg.sv
rtl/xed_front.sv
rtl/xed_cmd_queue.sv
rtl/xed_back.sv
rtl/xml_entity_decoder_top.sv
bench/xed_checker.sv
bench/tb_xml_entity_decoder_top.sv
